[src/bs3_pkg.sv]
// Shared types and constants of the 3x3 RGB box smoother.
`timescale 1ns / 1ps
package bs3_pkg;

  localparam int CH_BITS  = 16;
  localparam int SUM_BITS = CH_BITS + 4;   // nine channel values
  localparam int RCP_BITS = 19;

  // Reciprocals for the truncated divides by nine and by three
  localparam logic [RCP_BITS-1:0] RECIP9 = RCP_BITS'(233017); // ceil(2^21 / 9)
  localparam logic [RCP_BITS-1:0] RECIP3 = RCP_BITS'(349526); // ceil(2^20 / 3)
  localparam int SHIFT9 = 21;
  localparam int SHIFT3 = 20;

  typedef struct packed {
    logic [CH_BITS-1:0] red;
    logic [CH_BITS-1:0] green;
    logic [CH_BITS-1:0] blue;
  } pix_t;

  typedef logic [SUM_BITS-1:0] sum_t;

  // Which neighbours of the centre lie inside the image, plus the emit and frame-last flags
  typedef struct packed {
    logic emit;
    logic last;
    logic top_ok;
    logic bot_ok;
    logic left_ok;
    logic right_ok;
  } clip_t;

  typedef enum logic [1:0] {
    DIV1 = 2'd0,
    DIV4 = 2'd1,
    DIV6 = 2'd2,
    DIV9 = 2'd3
  } div_sel_t;

endpackage

[src/bs3_if.sv]
// Stream interfaces for source pixels and smoothed pixels.
`timescale 1ns / 1ps
interface bs3_in_if;
  logic                         valid;
  logic                         ready;
  logic                         opcode;
  logic [bs3_pkg::CH_BITS-1:0]  red_in;
  logic [bs3_pkg::CH_BITS-1:0]  green_in;
  logic [bs3_pkg::CH_BITS-1:0]  blue_in;
  modport source (output valid, opcode, red_in, green_in, blue_in, input ready);
  modport sink (input valid, opcode, red_in, green_in, blue_in, output ready);
endinterface

interface bs3_out_if;
  logic                         valid;
  logic                         ready;
  logic [bs3_pkg::CH_BITS-1:0]  red_out;
  logic [bs3_pkg::CH_BITS-1:0]  green_out;
  logic [bs3_pkg::CH_BITS-1:0]  blue_out;
  logic                         frame_end;
  modport source (output valid, red_out, green_out, blue_out, frame_end, input ready);
  modport sink (input valid, red_out, green_out, blue_out, frame_end, output ready);
endinterface

[src/bs3_line_mem.sv]
// Ring of the two previous image rows: one write port, two registered read ports.
`timescale 1ns / 1ps
module bs3_line_mem #(
  parameter int AW = 11
) (
  input  logic          clk,
  input  logic          en,
  input  logic [AW-1:0] wr_addr,
  input  bs3_pkg::pix_t wr_data,
  input  logic [AW-1:0] rd_addr,
  output bs3_pkg::pix_t top_q,
  output bs3_pkg::pix_t mid_q
);

  bs3_pkg::pix_t mem [2**AW];

  // Read the old top value before overwriting the same entry
  always_ff @(posedge clk) begin
    if (en) begin
      top_q <= mem[wr_addr];
      mid_q <= mem[rd_addr];
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

[src/bs3_window.sv]
// 3x3 window registers and the clipped per-channel sums.
`timescale 1ns / 1ps
module bs3_window (
  input  logic          clk,
  input  logic          shift_en,
  input  logic          sum_en,
  input  bs3_pkg::pix_t top_col,
  input  bs3_pkg::pix_t mid_col,
  input  bs3_pkg::pix_t cur_col,
  input  bs3_pkg::clip_t clip,
  output bs3_pkg::sum_t sum_red,
  output bs3_pkg::sum_t sum_green,
  output bs3_pkg::sum_t sum_blue
);

  bs3_pkg::pix_t win_r [3][3];   // [row][col], col 2 newest
  logic [2:0] row_ok;
  logic [2:0] col_ok;
  bs3_pkg::sum_t acc_r, acc_g, acc_b;

  // Advance the window by one column
  always_ff @(posedge clk) begin
    if (shift_en) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r][0] <= win_r[r][1];
        win_r[r][1] <= win_r[r][2];
      end
      win_r[0][2] <= top_col;
      win_r[1][2] <= mid_col;
      win_r[2][2] <= cur_col;
    end
  end

  // Add the entries that lie inside the image
  always_comb begin
    row_ok = {clip.bot_ok, 1'b1, clip.top_ok};
    col_ok = {clip.right_ok, 1'b1, clip.left_ok};
    acc_r  = '0;
    acc_g  = '0;
    acc_b  = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (row_ok[r] && col_ok[c]) begin
          acc_r = acc_r + bs3_pkg::SUM_BITS'(win_r[r][c].red);
          acc_g = acc_g + bs3_pkg::SUM_BITS'(win_r[r][c].green);
          acc_b = acc_b + bs3_pkg::SUM_BITS'(win_r[r][c].blue);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sum_en) begin
      sum_red   <= acc_r;
      sum_green <= acc_g;
      sum_blue  <= acc_b;
    end
  end

endmodule

[src/bs3_div.sv]
// Truncated divide of the three sums by 1, 4, 6 or 9; 6 and 9 via reciprocal multiply.
`timescale 1ns / 1ps
module bs3_div (
  input  logic                          clk,
  input  logic                          en,
  input  bs3_pkg::div_sel_t             sel,
  input  bs3_pkg::sum_t                 sum_red,
  input  bs3_pkg::sum_t                 sum_green,
  input  bs3_pkg::sum_t                 sum_blue,
  output logic [bs3_pkg::CH_BITS-1:0]   red_q,
  output logic [bs3_pkg::CH_BITS-1:0]   green_q,
  output logic [bs3_pkg::CH_BITS-1:0]   blue_q
);

  localparam int PW = bs3_pkg::SUM_BITS + bs3_pkg::RCP_BITS;

  bs3_pkg::sum_t sums [3];
  logic [bs3_pkg::CH_BITS-1:0] quot [3];

  assign sums[0] = sum_red;
  assign sums[1] = sum_green;
  assign sums[2] = sum_blue;

  // At most one multiply per channel; divide by six is a halving then a divide by three
  always_comb begin
    logic [PW-1:0] prod;
    for (int ch = 0; ch < 3; ch++) begin
      prod = '0;
      unique case (sel)
        bs3_pkg::DIV1: quot[ch] = bs3_pkg::CH_BITS'(sums[ch]);
        bs3_pkg::DIV4: quot[ch] = bs3_pkg::CH_BITS'(sums[ch] >> 2);
        bs3_pkg::DIV6: begin
          prod = PW'(sums[ch] >> 1) * PW'(bs3_pkg::RECIP3);
          quot[ch] = bs3_pkg::CH_BITS'(prod >> bs3_pkg::SHIFT3);
        end
        bs3_pkg::DIV9: begin
          prod = PW'(sums[ch]) * PW'(bs3_pkg::RECIP9);
          quot[ch] = bs3_pkg::CH_BITS'(prod >> bs3_pkg::SHIFT9);
        end
        default: quot[ch] = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      red_q   <= quot[0];
      green_q <= quot[1];
      blue_q  <= quot[2];
    end
  end

endmodule

[src/box_smooth_3x3_rgb.sv]
// Top level of the streaming 3x3 box-mean filter for square RGB images.
//
// Channels: in_ch carries beats of {opcode, red_in, green_in, blue_in};
// opcode 0 is a source pixel in raster order, 1 a drain tick. out_ch carries
// {red_out, green_out, blue_out, frame_end}, each the truncated mean of the
// pixel's 3x3 neighbourhood clipped to the image. cfg_we/cfg_wdata set the
// image side and restart the frame.
// The result for a pixel leaves after the beat image_side+1 beats later; once
// the whole frame is in, image_side+1 drain ticks flush the rest. Pixels that
// arrive while draining and drain ticks that arrive early are dropped.
// Each taken beat runs through line-store read (on take) and window shift
// (ST_READ); a beat that makes a result goes on through sum (ST_SUM) and
// divide (ST_DIV). There is a single line-store access per taken beat; a
// dropped beat is accepted in ST_IDLE and goes no further. in_ch is ready
// only in ST_IDLE, so a new beat is taken only once the last is through.
// A finished result sits in the output register, so the next beat is taken
// while it waits; a stalled receiver holds the block in the divide step
// only when a second result is ready.
// Reset: side 64, empty frame, nothing pending. The line store is not
// cleared; its stale entries only feed window places that clipping drops.
`timescale 1ns / 1ps
module box_smooth_3x3_rgb #(
  parameter int MAX_SIDE = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  bs3_in_if.sink            in_ch,
  bs3_out_if.source         out_ch,
  input  logic              cfg_we,
  input  logic [10:0]       cfg_wdata
);

  localparam int SW = $clog2(MAX_SIDE + 2);
  localparam int AW = $clog2(2 * MAX_SIDE);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_SUM  = 4'b0100,
    ST_DIV  = 4'b1000
  } state_t;

  function automatic logic [SW-1:0] eff_side(input logic [10:0] v);
    logic [SW-1:0] s;
    if (v == 11'd0) s = SW'(1);
    else if (32'(v) > MAX_SIDE) s = SW'(MAX_SIDE);
    else s = SW'(v);
    return s;
  endfunction

  state_t            state_r;
  logic [10:0]       side_r;
  logic [SW-1:0]     s;
  logic [AW:0]       ring;
  logic [AW-1:0]     wa_r, rb_r;
  logic [SW-1:0]     kr_r, kc_r, qi_r, qj_r, pre_r;
  logic              all_in_r;
  logic              out_valid_r, fe_r;
  bs3_pkg::clip_t    ctl_r, clip_new;
  bs3_pkg::pix_t     cur_r, cur_new, top_q, mid_q;
  bs3_pkg::sum_t     sum_red, sum_green, sum_blue;
  bs3_pkg::div_sel_t sel_r;
  logic              accept, take, drain, emit_now, out_free;

  assign s        = eff_side(side_r);
  assign ring     = {s, 1'b0};
  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept   = in_ch.valid && in_ch.ready;
  assign drain    = in_ch.opcode;
  assign take     = accept && (drain == all_in_r);
  assign emit_now = (pre_r == s + SW'(1));
  assign out_free = !out_valid_r || out_ch.ready;

  // Drain ticks enter as zero
  always_comb begin
    cur_new = drain ? bs3_pkg::pix_t'('0) :
              bs3_pkg::pix_t'{red: in_ch.red_in, green: in_ch.green_in,
                              blue: in_ch.blue_in};
    clip_new.emit     = emit_now;
    clip_new.top_ok   = (qi_r != '0);
    clip_new.bot_ok   = (qi_r != s - SW'(1));
    clip_new.left_ok  = (qj_r != '0);
    clip_new.right_ok = (qj_r != s - SW'(1));
    clip_new.last     = emit_now && !clip_new.bot_ok && !clip_new.right_ok;
  end

  bs3_line_mem #(.AW(AW)) u_mem (
    .clk     (clk),
    .en      (take),
    .wr_addr (wa_r),
    .wr_data (cur_new),
    .rd_addr (rb_r),
    .top_q   (top_q),
    .mid_q   (mid_q)
  );

  bs3_window u_win (
    .clk       (clk),
    .shift_en  (state_r == ST_READ),
    .sum_en    (state_r == ST_SUM),
    .top_col   (top_q),
    .mid_col   (mid_q),
    .cur_col   (cur_r),
    .clip      (ctl_r),
    .sum_red   (sum_red),
    .sum_green (sum_green),
    .sum_blue  (sum_blue)
  );

  bs3_div u_div (
    .clk       (clk),
    .en        (state_r == ST_DIV && out_free),
    .sel       (sel_r),
    .sum_red   (sum_red),
    .sum_green (sum_green),
    .sum_blue  (sum_blue),
    .red_q     (out_ch.red_out),
    .green_q   (out_ch.green_out),
    .blue_q    (out_ch.blue_out)
  );

  assign out_ch.valid     = out_valid_r;
  assign out_ch.frame_end = fe_r;

  // Hold the beat and its clipping for the later steps, and pick the divisor in the sum step
  always_ff @(posedge clk) begin
    if (take) begin
      cur_r <= cur_new;
      ctl_r <= clip_new;
    end
    if (state_r == ST_SUM) begin
      priority if (ctl_r.top_ok == ctl_r.bot_ok && ctl_r.left_ok == ctl_r.right_ok)
        sel_r <= (ctl_r.top_ok && ctl_r.left_ok) ? bs3_pkg::DIV9 :
                 (ctl_r.top_ok || ctl_r.left_ok) ? bs3_pkg::DIV1 : bs3_pkg::DIV1;
      else if (ctl_r.top_ok != ctl_r.bot_ok && ctl_r.left_ok != ctl_r.right_ok)
        sel_r <= bs3_pkg::DIV4;
      else if ((ctl_r.top_ok && ctl_r.bot_ok) || (ctl_r.left_ok && ctl_r.right_ok))
        sel_r <= bs3_pkg::DIV6;
      else
        sel_r <= bs3_pkg::DIV4;
    end
  end

  // Frame counters, ring pointers and the step sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      side_r      <= 11'd64;
      wa_r        <= '0;
      rb_r        <= AW'(eff_side(11'd64));
      kr_r        <= '0;
      kc_r        <= '0;
      qi_r        <= '0;
      qj_r        <= '0;
      pre_r       <= '0;
      all_in_r    <= 1'b0;
      out_valid_r <= 1'b0;
      fe_r        <= 1'b0;
    end else begin
      // Load a new result or hold the waiting one until taken
      out_valid_r <= (state_r == ST_DIV && out_free) || (out_valid_r && !out_ch.ready);
      unique case (state_r)
        ST_IDLE: if (take) state_r <= ST_READ;
        ST_READ: state_r <= ctl_r.emit ? ST_SUM : ST_IDLE;
        ST_SUM:  state_r <= ST_DIV;
        ST_DIV: begin
          if (out_free) begin
            fe_r        <= ctl_r.last;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
      if (cfg_we) begin
        side_r   <= cfg_wdata;
        wa_r     <= '0;
        rb_r     <= AW'(eff_side(cfg_wdata));
        kr_r     <= '0;
        kc_r     <= '0;
        qi_r     <= '0;
        qj_r     <= '0;
        pre_r    <= '0;
        all_in_r <= 1'b0;
      end else if (take) begin
        if (clip_new.last) begin
          wa_r     <= '0;
          rb_r     <= AW'(s);
          kr_r     <= '0;
          kc_r     <= '0;
          qi_r     <= '0;
          qj_r     <= '0;
          pre_r    <= '0;
          all_in_r <= 1'b0;
        end else begin
          wa_r <= ({1'b0, wa_r} + 1'b1 == ring) ? '0 : wa_r + 1'b1;
          rb_r <= ({1'b0, rb_r} + 1'b1 == ring) ? '0 : rb_r + 1'b1;
          if (!emit_now) pre_r <= pre_r + 1'b1;
          if (emit_now) begin
            if (qj_r == s - SW'(1)) begin
              qj_r <= '0;
              qi_r <= qi_r + 1'b1;
            end else begin
              qj_r <= qj_r + 1'b1;
            end
          end
          if (!drain) begin
            if (kc_r == s - SW'(1)) begin
              kc_r <= '0;
              kr_r <= kr_r + 1'b1;
              if (kr_r == s - SW'(1)) all_in_r <= 1'b1;
            end else begin
              kc_r <= kc_r + 1'b1;
            end
          end
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_wa_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, wa_r} < ring))
    else $error("line store write pointer outside ring");

  a_sum_needs_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SUM) |-> ctl_r.emit)
    else $error("sum step entered for a beat with no result");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ && ctl_r.last) |-> (pre_r == '0 && !all_in_r))
    else $error("frame counters not cleared after frame end");
`endif

endmodule
